/* hdl/pwvm_pkg.sv */
// Shared constants, register indexes and pipeline payload types for the
// pooling window valid mask block. No dependencies.
`timescale 1ns / 1ps

package pwvm_pkg;

   localparam int MASK_BITS   = 32;
   localparam int LANE_W      = $clog2(MASK_BITS);
   localparam int LEFT_W      = LANE_W + 1;
   localparam int GROUP_W     = 27;
   localparam int TAP_W       = 8;
   localparam int HALF_W      = 16;
   localparam int WORD_W      = 32;
   localparam int COORD_W     = 35;
   localparam int PROD_W      = 2 * HALF_W;
   localparam int TAPPROD_W   = TAP_W + HALF_W;
   localparam int CSR_INDEX_W = 3;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 32;

   // Divider: one quotient bit per step, a few steps per stage
   localparam int DIV_STEPS_PER_STAGE = 4;
   localparam int DIV_STAGES          = WORD_W / DIV_STEPS_PER_STAGE;

   // Mask lanes: a short dependent chain per stage
   localparam int LANES_PER_STAGE = 2;
   localparam int LANE_STAGES     = MASK_BITS / LANES_PER_STAGE;

   localparam logic [WORD_W-1:0] STRIDE_RESET   = 32'h0001_0001;
   localparam logic [WORD_W-1:0] DILATION_RESET = 32'h0001_0001;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_OUT_SHAPE = 3'd0,
      REG_IN_SHAPE  = 3'd1,
      REG_STRIDE    = 3'd2,
      REG_PADDING   = 3'd3,
      REG_DILATION  = 3'd4
   } reg_index_type;

   // Decoded configuration halves
   typedef struct packed {
      logic [HALF_W-1:0] p;
      logic [HALF_W-1:0] q;
      logic [HALF_W-1:0] h;
      logic [HALF_W-1:0] w;
      logic [HALF_W-1:0] sh;
      logic [HALF_W-1:0] sw;
      logic [HALF_W-1:0] ph;
      logic [HALF_W-1:0] pw;
      logic [HALF_W-1:0] dh;
      logic [HALF_W-1:0] dw;
   } cfg_type;

   // Divider stage payload: work holds dividend bits shifting out and
   // quotient bits shifting in
   typedef struct packed {
      logic [HALF_W-1:0] rem;
      logic [WORD_W-1:0] work;
      logic [WORD_W-1:0] base;
      logic [WORD_W-1:0] total;
      logic [TAP_W-1:0]  r;
      logic [TAP_W-1:0]  s;
   } div_type;

   // Product stage payload
   typedef struct packed {
      logic [PROD_W-1:0]    prod_h;
      logic [PROD_W-1:0]    prod_w;
      logic [TAPPROD_W-1:0] rd;
      logic [TAPPROD_W-1:0] sd;
      logic [LEFT_W-1:0]    left;
      logic [HALF_W-1:0]    q;
   } prod_type;

   // Lane chain payload: tap coordinates of the next lane to test
   typedef struct packed {
      logic signed [COORD_W-1:0] h;
      logic signed [COORD_W-1:0] w;
      logic signed [COORD_W-1:0] wz;
      logic [HALF_W-1:0]         q;
      logic [LEFT_W-1:0]         left;
      logic [MASK_BITS-1:0]      mask;
   } lane_type;

endpackage

/* hdl/pool_window_valid_mask.sv */
// Top level of the pooling window valid mask block: configuration registers
// and the divider, product and lane pipelines. Depends on pwvm_pkg,
// pwvm_div, pwvm_tap and pwvm_lane.
`timescale 1ns / 1ps

// Usage
//   req_* : one request transaction per mask: a group of 32 output pixels in
//           raster order plus one window tap (row, column).
//   rsp_* : one result transaction per request, in request order: bit i set
//           when pixel 32*group+i exists and its tap lands inside the image.
//   csr_* : register writes (output shape, input shape, stride, padding,
//           dilation) by index; always ready, unknown indexes dropped.
//           Write only while no request is in flight.
// Pipeline: 26 register stages (8 divider stages at 4 quotient bits each,
//   2 product/offset stages, 16 lane stages at 2 mask lanes each).
// Throughput: one request per cycle, sustained while the output is not stalled.
// Reset: synchronous, active high; empties the pipeline and loads the
//   register defaults (unit stride and dilation, everything else zero).
// Stall: when rsp_tready is low the result holds in the output stage;
//   earlier stages keep advancing into empty slots, so requests are still
//   taken until the pipeline is full. Nothing is dropped or repeated.

module pool_window_valid_mask
   import pwvm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request: [26:0] group_index, [34:27] tap_row, [42:35] tap_col, rest 0
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // result: [31:0] valid_mask
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_data
);

   logic [WORD_W-1:0] out_shape_ff,  out_shape_in;
   logic [WORD_W-1:0] in_shape_ff,   in_shape_in;
   logic [WORD_W-1:0] stride_ff,     stride_in;
   logic [WORD_W-1:0] padding_ff,    padding_in;
   logic [WORD_W-1:0] dilation_ff,   dilation_in;
   cfg_type           cfg;

   logic     div_valid;
   logic     div_ready;
   div_type  div_data;
   logic     tap_valid;
   logic     tap_ready;
   lane_type tap_data;

   assign csr_ready = 1'b1;

   // Register writes: take the transaction, drop unknown indexes
   always_comb begin
      out_shape_in = out_shape_ff;
      in_shape_in  = in_shape_ff;
      stride_in    = stride_ff;
      padding_in   = padding_ff;
      dilation_in  = dilation_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_OUT_SHAPE: out_shape_in = csr_data;
            REG_IN_SHAPE:  in_shape_in  = csr_data;
            REG_STRIDE:    stride_in    = csr_data;
            REG_PADDING:   padding_in   = csr_data;
            REG_DILATION:  dilation_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_shape_ff <= '0;
         in_shape_ff  <= '0;
         stride_ff    <= STRIDE_RESET;
         padding_ff   <= '0;
         dilation_ff  <= DILATION_RESET;
      end else begin
         out_shape_ff <= out_shape_in;
         in_shape_ff  <= in_shape_in;
         stride_ff    <= stride_in;
         padding_ff   <= padding_in;
         dilation_ff  <= dilation_in;
      end
   end

   // Split registers into their halves
   assign cfg.p  = out_shape_ff[WORD_W-1:HALF_W];
   assign cfg.q  = out_shape_ff[HALF_W-1:0];
   assign cfg.h  = in_shape_ff[WORD_W-1:HALF_W];
   assign cfg.w  = in_shape_ff[HALF_W-1:0];
   assign cfg.sh = stride_ff[WORD_W-1:HALF_W];
   assign cfg.sw = stride_ff[HALF_W-1:0];
   assign cfg.ph = padding_ff[WORD_W-1:HALF_W];
   assign cfg.pw = padding_ff[HALF_W-1:0];
   assign cfg.dh = dilation_ff[WORD_W-1:HALF_W];
   assign cfg.dw = dilation_ff[HALF_W-1:0];

   // Row and column of the group's first pixel
   pwvm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_group  (req_tdata[GROUP_W-1:0]),
      .in_r      (req_tdata[GROUP_W+TAP_W-1:GROUP_W]),
      .in_s      (req_tdata[GROUP_W+2*TAP_W-1:GROUP_W+TAP_W]),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   // Tap coordinates of that pixel and count of existing pixels
   pwvm_tap u_tap (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (tap_valid),
      .out_ready (tap_ready),
      .out_data  (tap_data)
   );

   // Walk the 32 lanes; the last lane stage is the output register
   pwvm_lane u_lane (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (tap_valid),
      .in_ready  (tap_ready),
      .in_data   (tap_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_mask  (rsp_tdata)
   );

`ifndef SYNTHESIS
   // A free or draining output stage must let the whole pipeline move
   a_ready_chain: assert property (@(posedge clock)
      (rsp_tready || !rsp_tvalid) |-> req_tready)
      else $error("pipeline stalled while output stage could advance");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // Neither the result nor the tap unit output may be valid right after reset
   a_no_early_result: assert property (@(posedge clock)
      ($past(reset) || $past(reset, 2)) |-> (!rsp_tvalid && !tap_valid))
      else $error("stage valid set shortly after reset");
`endif

endmodule

/* hdl/pwvm_div.sv */
// Pipelined restoring divider: splits the group's first pixel index into
// output row and column. Depends on pwvm_pkg.
`timescale 1ns / 1ps

module pwvm_div
   import pwvm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [GROUP_W-1:0] in_group,
   input  logic [TAP_W-1:0]   in_r,
   input  logic [TAP_W-1:0]   in_s,
   output logic               out_valid,
   input  logic               out_ready,
   output div_type            out_data
);

   logic [DIV_STAGES-1:0] v_ff;
   div_type               st_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0] src_v;
   div_type               src_d [DIV_STAGES];
   div_type               st_in [DIV_STAGES];
   logic [DIV_STAGES:0]   adv;

   assign adv[DIV_STAGES] = out_ready;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_first
         always_comb begin
            src_v[k]       = in_valid;
            src_d[k].rem   = '0;
            src_d[k].work  = {in_group, {LANE_W{1'b0}}};
            src_d[k].base  = {in_group, {LANE_W{1'b0}}};
            src_d[k].total = WORD_W'(cfg.p) * WORD_W'(cfg.q);
            src_d[k].r     = in_r;
            src_d[k].s     = in_s;
         end
      end else begin : g_next
         assign src_v[k] = v_ff[k-1];
         assign src_d[k] = st_ff[k-1];
      end

      assign adv[k] = !v_ff[k] || adv[k+1];

      always_comb begin
         logic [HALF_W:0]   t;
         logic              ge;
         logic [HALF_W-1:0] rem;
         logic [WORD_W-1:0] work;
         rem  = src_d[k].rem;
         work = src_d[k].work;
         for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
            t    = {rem, work[WORD_W-1]};
            ge   = (t >= {1'b0, cfg.q});
            work = {work[WORD_W-2:0], ge};
            rem  = ge ? HALF_W'(t - {1'b0, cfg.q}) : t[HALF_W-1:0];
         end
         st_in[k]      = src_d[k];
         st_in[k].rem  = rem;
         st_in[k].work = work;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            v_ff[k] <= src_v[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_data  = st_ff[DIV_STAGES-1];

endmodule

/* hdl/pwvm_tap.sv */
// Two-stage product and offset unit: tap coordinates of the group's first
// pixel and the count of pixels that exist. Depends on pwvm_pkg.
`timescale 1ns / 1ps

module pwvm_tap
   import pwvm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  div_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output lane_type out_data
);

   logic     a_v_ff;
   logic     b_v_ff;
   prod_type a_ff;
   prod_type a_in;
   lane_type b_ff;
   lane_type b_in;
   logic     a_adv;
   logic     b_adv;

   assign b_adv    = !b_v_ff || out_ready;
   assign a_adv    = !a_v_ff || b_adv;
   assign in_ready = a_adv;

   // Products, and how many of the group's pixels lie inside the grid
   always_comb begin
      logic [WORD_W-1:0] diff;
      diff        = in_data.total - in_data.base;
      a_in.prod_h = PROD_W'(in_data.work[HALF_W-1:0]) * PROD_W'(cfg.sh);
      a_in.prod_w = PROD_W'(in_data.rem) * PROD_W'(cfg.sw);
      a_in.rd     = TAPPROD_W'(in_data.r) * TAPPROD_W'(cfg.dh);
      a_in.sd     = TAPPROD_W'(in_data.s) * TAPPROD_W'(cfg.dw);
      a_in.q      = in_data.rem;
      if (in_data.base >= in_data.total) begin
         a_in.left = '0;
      end else if (diff >= WORD_W'(MASK_BITS)) begin
         a_in.left = LEFT_W'(MASK_BITS);
      end else begin
         a_in.left = diff[LEFT_W-1:0];
      end
   end

   // Sum into signed coordinates
   always_comb begin
      b_in.h    = $signed(COORD_W'(a_ff.prod_h)) - $signed(COORD_W'(cfg.ph))
                  + $signed(COORD_W'(a_ff.rd));
      b_in.w    = $signed(COORD_W'(a_ff.prod_w)) - $signed(COORD_W'(cfg.pw))
                  + $signed(COORD_W'(a_ff.sd));
      b_in.wz   = $signed(COORD_W'(a_ff.sd)) - $signed(COORD_W'(cfg.pw));
      b_in.q    = a_ff.q;
      b_in.left = a_ff.left;
      b_in.mask = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         if (a_adv) begin
            a_v_ff <= in_valid;
         end
         if (b_adv) begin
            b_v_ff <= a_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         a_ff <= a_in;
      end
      if (b_adv) begin
         b_ff <= b_in;
      end
   end

   assign out_valid = b_v_ff;
   assign out_data  = b_ff;

endmodule

/* hdl/pwvm_lane.sv */
// Lane chain: tests a few mask lanes per stage and steps the tap position
// along the output row, wrapping to the next row. Depends on pwvm_pkg.
`timescale 1ns / 1ps

module pwvm_lane
   import pwvm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  lane_type             in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [MASK_BITS-1:0] out_mask
);

   logic [LANE_STAGES-1:0] v_ff;
   lane_type               st_ff [LANE_STAGES];
   logic [LANE_STAGES-1:0] src_v;
   lane_type               src_d [LANE_STAGES];
   lane_type               st_in [LANE_STAGES];
   logic [LANE_STAGES:0]   adv;
   logic signed [COORD_W-1:0] h_lim;
   logic signed [COORD_W-1:0] w_lim;
   logic signed [COORD_W-1:0] sh_step;
   logic signed [COORD_W-1:0] sw_step;
   logic [HALF_W-1:0]         q_last;

   assign h_lim   = $signed(COORD_W'(cfg.h));
   assign w_lim   = $signed(COORD_W'(cfg.w));
   assign sh_step = $signed(COORD_W'(cfg.sh));
   assign sw_step = $signed(COORD_W'(cfg.sw));
   assign q_last  = cfg.q - HALF_W'(1);

   assign adv[LANE_STAGES] = out_ready;

   for (genvar k = 0; k < LANE_STAGES; k++) begin : g_stage
      localparam int BASE_LANE = k * LANES_PER_STAGE;

      if (k == 0) begin : g_first
         assign src_v[k] = in_valid;
         assign src_d[k] = in_data;
      end else begin : g_next
         assign src_v[k] = v_ff[k-1];
         assign src_d[k] = st_ff[k-1];
      end

      assign adv[k] = !v_ff[k] || adv[k+1];

      always_comb begin
         logic signed [COORD_W-1:0] h;
         logic signed [COORD_W-1:0] w;
         logic [HALF_W-1:0]         q;
         logic [MASK_BITS-1:0]      mask;
         logic                      in_img;
         h    = src_d[k].h;
         w    = src_d[k].w;
         q    = src_d[k].q;
         mask = src_d[k].mask;
         for (int j = 0; j < LANES_PER_STAGE; j++) begin
            in_img = (h >= 0) && (h < h_lim) && (w >= 0) && (w < w_lim)
                     && (LEFT_W'(BASE_LANE + j) < src_d[k].left);
            mask[LANE_W'(BASE_LANE + j)] = in_img;
            // step to the next pixel, wrapping at the row end
            if (q == q_last) begin
               q = '0;
               h = h + sh_step;
               w = src_d[k].wz;
            end else begin
               q = q + HALF_W'(1);
               w = w + sw_step;
            end
         end
         st_in[k]      = src_d[k];
         st_in[k].h    = h;
         st_in[k].w    = w;
         st_in[k].q    = q;
         st_in[k].mask = mask;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            v_ff[k] <= src_v[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[LANE_STAGES-1];
   assign out_mask  = st_ff[LANE_STAGES-1].mask;

endmodule
